>>> sv/swbr_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window bad ratio package
// Register indexes, operation codes and field widths shared by the block.
// ----------------------------------------------------------------------------
package swbr_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam int unsigned TOTAL_W     = 10;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [TOTAL_W-1:0]     total_type;

   localparam csr_index_type CSR_WINDOW_LENGTH = 2'd0;
   localparam csr_index_type CSR_RAISE_LEVEL   = 2'd1;
   localparam csr_index_type CSR_CLEAR_LEVEL   = 2'd2;

   localparam logic FUNC_RECORD = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   localparam csr_data_type WINDOW_LENGTH_RESET = 10'd300;
   localparam csr_data_type RAISE_LEVEL_RESET   = 10'd180;
   localparam csr_data_type CLEAR_LEVEL_RESET   = 10'd120;

   localparam total_type TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

>>> sv/sliding_window_bad_ratio_hysteresis.sv
// ----------------------------------------------------------------------------
// Sliding window bad ratio with hysteresis
// Keeps a one-bit history ring of recent verdicts in a memory, a running
// bad count and a hysteretic alarm flag.
//
//   Channel  Direction  Handshake            Beat contents
//   req_     in         req_valid/req_stall  req_func, req_bad
//   rsp_     out        rsp_valid/rsp_stall  rsp_alarm, rsp_bad_total
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One beat is taken every cycle while req_stall is low. As it is accepted,
// the evicted history bit is read from the ring memory; the update stage then
// updates the count and flag, writes the new bit back and loads the result
// register; a read of the slot being written in the same cycle is forwarded.
// Reset is synchronous; the ring memory needs no clearing pass.
// req_stall is raised only while both the update stage and the result
// register are full and rsp_stall is high.
// ----------------------------------------------------------------------------
module sliding_window_bad_ratio_hysteresis #(
   parameter int unsigned MAX_WINDOW = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic                 req_bad,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_alarm,
   output swbr_pkg::total_type  rsp_bad_total,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  swbr_pkg::csr_index_type csr_index,
   input  swbr_pkg::csr_data_type  csr_wdata
);
   import swbr_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_WINDOW);
   localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int unsigned EW_W   = (CNT_W > CSR_DATA_W) ? CNT_W : CSR_DATA_W;

   logic                hist_mem [MAX_WINDOW];

   csr_data_type        window_ff;
   csr_data_type        raise_ff;
   csr_data_type        clear_ff;

   logic [ADDR_W-1:0]   slot_ff;
   logic [EW_W-1:0]     fill_ff;
   total_type           tally_ff;
   logic                alarm_ff;

   logic                s1_valid_ff;
   logic                s1_func_ff;
   logic                s1_bad_ff;
   logic                s1_evict_ff;
   logic [ADDR_W-1:0]   s1_slot_ff;
   logic                rd_bit_ff;
   logic                fwd_ff;
   logic                fwd_bit_ff;

   logic                rsp_valid_ff;
   logic                rsp_alarm_ff;
   total_type           rsp_total_ff;

   logic [EW_W-1:0]     win_raw;
   logic [EW_W-1:0]     eff_win;
   logic [EW_W-1:0]     slot_ext;
   logic [ADDR_W-1:0]   slot_cur;
   logic [EW_W-1:0]     slot_inc;
   logic [ADDR_W-1:0]   slot_in;
   logic                evict;
   logic [EW_W-1:0]     fill_in;
   logic                out_free;
   logic                s1_adv;
   logic                s1_done;
   logic                req_fire;
   logic                csr_fire;
   logic                old_bit;
   total_type           tally_dec;
   total_type           tally_in;
   logic                alarm_in;

   assign win_raw  = EW_W'(window_ff);
   assign eff_win  = (win_raw == '0) ? EW_W'(1) :
                     ((win_raw > EW_W'(MAX_WINDOW)) ? EW_W'(MAX_WINDOW) : win_raw);

   assign slot_ext = EW_W'(slot_ff);
   assign slot_cur = (slot_ext >= eff_win) ? '0 : slot_ff;
   assign slot_inc = EW_W'(slot_cur) + EW_W'(1);
   assign slot_in  = (slot_inc >= eff_win) ? '0 : slot_inc[ADDR_W-1:0];
   assign evict    = (fill_ff >= eff_win);
   assign fill_in  = evict ? fill_ff : (fill_ff + EW_W'(1));

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = !s1_valid_ff || out_free;
   assign s1_done   = s1_valid_ff && out_free;
   assign req_stall = !s1_adv;
   assign req_fire  = req_valid && s1_adv;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;

   assign old_bit   = fwd_ff ? fwd_bit_ff : rd_bit_ff;

   always_comb begin
      tally_dec = tally_ff;
      if (s1_evict_ff && old_bit && (tally_ff != '0)) begin
         tally_dec = tally_ff - TOTAL_W'(1);
      end
      tally_in = tally_dec;
      if (s1_bad_ff && (tally_dec != TOTAL_MAX)) begin
         tally_in = tally_dec + TOTAL_W'(1);
      end
      if (tally_in >= raise_ff) begin
         alarm_in = 1'b1;
      end else if (tally_in <= clear_ff) begin
         alarm_in = 1'b0;
      end else begin
         alarm_in = alarm_ff;
      end
      if (s1_func_ff == FUNC_CLEAR) begin
         tally_in = '0;
         alarm_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_done && (s1_func_ff == FUNC_RECORD)) begin
         hist_mem[s1_slot_ff] <= s1_bad_ff;
      end
      if (req_fire) begin
         rd_bit_ff <= hist_mem[slot_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff  <= req_func;
         s1_bad_ff   <= req_bad;
         s1_evict_ff <= evict;
         s1_slot_ff  <= slot_cur;
         fwd_ff      <= s1_done && (s1_func_ff == FUNC_RECORD) && (s1_slot_ff == slot_cur);
         fwd_bit_ff  <= s1_bad_ff;
      end
      if (s1_done) begin
         rsp_alarm_ff <= alarm_in;
         rsp_total_ff <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_LENGTH_RESET;
         raise_ff     <= RAISE_LEVEL_RESET;
         clear_ff     <= CLEAR_LEVEL_RESET;
         slot_ff      <= '0;
         fill_ff      <= '0;
         tally_ff     <= '0;
         alarm_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_done) begin
            tally_ff <= tally_in;
            alarm_ff <= alarm_in;
         end
         if (req_fire) begin
            if (req_func == FUNC_CLEAR) begin
               slot_ff <= '0;
               fill_ff <= '0;
            end else begin
               slot_ff <= slot_in;
               fill_ff <= fill_in;
            end
         end
         if (csr_fire) begin
            case (csr_index)
               CSR_WINDOW_LENGTH: begin
                  window_ff <= csr_wdata;
                  slot_ff   <= '0;
                  fill_ff   <= '0;
                  tally_ff  <= '0;
                  alarm_ff  <= 1'b0;
               end
               CSR_RAISE_LEVEL: begin
                  raise_ff <= csr_wdata;
               end
               CSR_CLEAR_LEVEL: begin
                  clear_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_alarm     = rsp_alarm_ff;
   assign rsp_bad_total = rsp_total_ff;

   // The write slot always lies inside the active window.
   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      slot_ext < eff_win)
      else $error("write slot outside the window");

   // The fill level never passes the active window.
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_win)
      else $error("fill level beyond the window");

   // An accepted beat reaches the update stage in the next cycle.
   a_accept_to_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted beat lost before the update stage");

   // A blocked update stage keeps its beat.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_slot_ff)))
      else $error("update stage dropped a blocked beat");

endmodule
